// ----- design/linear_interp_resampler_defines.svh -----
// Assertion helpers used by the resampler top level.
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lir_pkg.sv -----
`default_nettype none

package lir_pkg;

    localparam int NUM_FIELDS       = 8;
    localparam int SAMPLE_W         = 16;
    localparam int TDATA_W          = NUM_FIELDS * SAMPLE_W;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_CH_W   = 4;
    localparam int RATIO_W    = 20;
    localparam int RAMP_W     = 16;

    localparam int PHASE_W = 20;
    localparam int CUR_W   = 28;
    localparam int STEP_W  = 29;

    localparam int RUN_CAP = 64;
    localparam int CNT_W   = $clog2(RUN_CAP);

    localparam int QUEUE_DEPTH = 2;

    localparam int DIV_STEPS = CUR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PHASE_W-1:0]  ONE_Q16   = PHASE_W'(20'h10000);
    localparam logic [PHASE_W-1:0]  PHASE_MAX = '1;
    localparam logic [CUR_W-1:0]    CUR_MAX   = '1;

    localparam logic [CFG_CH_W-1:0] NUM_CH_RST = CFG_CH_W'(2);
    localparam logic [RATIO_W-1:0]  TARGET_RST = RATIO_W'(65536);
    localparam logic [RAMP_W-1:0]   RAMP_RST   = '0;
    localparam logic [CUR_W-1:0]    CUR_RST    = CUR_W'(28'h100_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CHANNELS = 2'd0,
        CFG_TARGET_RATIO = 2'd1,
        CFG_RAMP_FRAMES  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               load_only;
        logic [TDATA_W-1:0] samples;
    } frame_entry_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

    typedef struct packed {
        logic              start;
        logic              negative;
        logic [CUR_W-1:0]  magnitude;
        logic [RAMP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [STEP_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/linear_interp_resampler.sv -----
// Each output frame runs its MAX_CHANNELS lanes through the shared multiplier in turn.
// An input item gives N output frames, or none when it only advances the phase;
// a two-entry frame queue lets input run ahead of the engine.
// From idle, an accepted item passes the queue and the MAC, DRAIN and EMIT states to the output.
// A target_ratio write with a nonzero ramp blocks input while the step divides.
// rst_n is asynchronous: it clears the queue, phase, ratio, ramp and registers to defaults.
`default_nettype none

`include "linear_interp_resampler_defines.svh"

module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // sample_0 .. sample_7, 16 bits each, sample_0 in the lowest bits
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_0 .. out_7, 16 bits each, out_0 in the lowest bits
    output logic [TDATA_W-1:0]         m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    q_status_t    q_stat;
    frame_entry_t push_entry;
    frame_entry_t head;
    logic         q_push;
    logic         q_pop;
    logic         div_busy;

    lir_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .hold          (div_busy),
        .q_stat        (q_stat),
        .push          (q_push),
        .push_entry    (push_entry)
    );

    lir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    lir_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (q_pop),
        .busy          (div_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `LIR_ASSERT_NOW(a_hold_during_div, div_busy, !s_axis_tready, "input taken while dividing")
    `LIR_ASSERT_NOW(a_no_push_full, q_push, q_stat.not_full, "push into a full queue")
    `LIR_ASSERT_NOW(a_no_pop_empty, q_pop, q_stat.not_empty, "pop from an empty queue")
    `LIR_ASSERT_NEXT(a_push_fills, q_push, q_stat.not_empty, "queue empty after a push")

endmodule

`default_nettype wire

// ----- design/lir_div.sv -----
`default_nettype none

// Restoring divider for the ramp step, one quotient bit per cycle.
module lir_div
    import lir_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RAMP_W-1:0]    rem_reg;
    logic [CUR_W-1:0]     dvd_reg;
    logic                 neg_reg;
    logic [RAMP_W-1:0]    dvs_reg;

    logic [RAMP_W:0]      shifted;
    logic                 fits;
    logic [RAMP_W:0]      rem_diff;
    logic [RAMP_W-1:0]    rem_next;
    logic [STEP_W-1:0]    quo_mag;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[CUR_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_diff = shifted - {1'b0, dvs_reg};
        rem_next = fits ? rem_diff[RAMP_W-1:0] : shifted[RAMP_W-1:0];
        quo_mag  = {1'b0, dvd_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.magnitude;
            neg_reg <= req.negative;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[CUR_W-2:0], fits};
        end
    end

    // The quotient builds up in the dividend register as its bits shift out.
    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(-quo_mag) : $signed(quo_mag);

endmodule

`default_nettype wire

// ----- design/lir_front.sv -----
`default_nettype none

// Accepts input frames and tags the first one after reset as load only.
module lir_front
    import lir_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // sample_0 .. sample_7, 16 bits each, sample_0 in the lowest bits
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    input  wire logic               hold,
    input  wire q_status_t          q_stat,
    output logic                    push,
    output frame_entry_t            push_entry
);

    logic have_prev_reg;

    assign s_axis_tready        = q_stat.not_full && !hold;
    assign push                 = s_axis_tvalid && s_axis_tready;
    assign push_entry.load_only = !have_prev_reg;
    assign push_entry.samples   = s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (push)
        begin
            have_prev_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- design/lir_queue.sv -----
`default_nettype none

// Small frame queue between the front and the back.
module lir_queue
    import lir_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire frame_entry_t push_entry,
    input  wire logic         pop,
    output frame_entry_t      head,
    output q_status_t         q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

    frame_entry_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_QW-1:0]   count_reg;

    assign head             = entry_reg[rd_ptr_reg];
    assign q_stat.not_empty = count_reg != '0;
    assign q_stat.not_full  = count_reg != FULL_CNT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- design/lir_back.sv -----
`default_nettype none

// Interpolation engine: holds the previous frame, the phase and the ratio
// ramp, and works out one channel per cycle on a shared multiplier.
module lir_back
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire q_status_t             q_stat,
    input  wire frame_entry_t          head,
    output logic                       pop,
    output logic                       busy,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_0 .. out_7, 16 bits each, out_0 in the lowest bits
    output logic [TDATA_W-1:0]         m_axis_tdata,
    output logic                       m_axis_tlast
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CH_W-1:0]     LAST_CH  = CH_W'(MAX_CHANNELS - 1);
    localparam logic [CFG_CH_W-1:0] CH_LIMIT = CFG_CH_W'(MAX_CHANNELS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    logic [CH_W-1:0]           ch_reg;
    logic                      s1_valid_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      out_valid_reg;
    logic                      out_last_reg;
    logic [TDATA_W-1:0]        out_data_reg;

    logic [CFG_CH_W-1:0]       num_ch_reg;
    logic [RATIO_W-1:0]        target_reg;
    logic [RAMP_W-1:0]         ramp_frames_reg;

    logic [PHASE_W-1:0]        phase_reg;
    logic [CUR_W-1:0]          cur_ratio_reg;
    logic signed [STEP_W-1:0]  step_reg;
    logic [RAMP_W-1:0]         ramp_cnt_reg;

    logic signed [SAMPLE_W-1:0] prev_reg [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] cur_reg  [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] res_reg  [MAX_CHANNELS];

    logic signed [2*SAMPLE_W+1:0] prod_reg;
    logic signed [SAMPLE_W-1:0]   a_reg;
    logic [CH_W-1:0]              idx_reg;

    logic signed [SAMPLE_W-1:0]   head_samples [MAX_CHANNELS];
    logic [CFG_CH_W-1:0]          used_ch;
    logic                         lane_active;
    logic signed [SAMPLE_W-1:0]   cur_s;
    logic signed [SAMPLE_W-1:0]   prev_s;
    logic signed [SAMPLE_W:0]     lane_diff;
    logic signed [SAMPLE_W:0]     lane_frac;
    logic signed [2*SAMPLE_W+1:0] lane_prod;
    logic signed [2*SAMPLE_W+1:0] rounded;
    logic [SAMPLE_W-1:0]          lane_result;
    logic [TDATA_W-1:0]           res_packed;

    logic                         slot_free;
    logic [PHASE_W:0]             phase_sum;
    logic [PHASE_W-1:0]           phase_next;
    logic                         run_more;
    logic [CUR_W-1:0]             goal;
    logic signed [CUR_W+1:0]      ratio_sum;
    logic [CUR_W-1:0]             ratio_clamped;
    logic [CUR_W-1:0]             cur_ratio_next;
    logic [RAMP_W-1:0]            ramp_cnt_next;

    logic [CUR_W:0]               target_diff;
    logic [CUR_W:0]               target_diff_neg;
    logic                         target_write;
    div_req_t                     div_req;
    div_rsp_t                     div_rsp;

    lir_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            head_samples[c] = head.samples[c*SAMPLE_W +: SAMPLE_W];
        end

        used_ch     = (num_ch_reg > CH_LIMIT) ? CH_LIMIT : num_ch_reg;
        lane_active = CFG_CH_W'(ch_reg) < used_ch;
        cur_s       = cur_reg[ch_reg];
        prev_s      = prev_reg[ch_reg];
        lane_diff   = {cur_s[SAMPLE_W-1], cur_s} - {prev_s[SAMPLE_W-1], prev_s};
        lane_frac   = {1'b0, phase_reg[SAMPLE_W-1:0]};
        lane_prod   = lane_diff * lane_frac;

        // Round half up at the integer grid of the Q18.16 product; the sum always lands in range.
        rounded     = prod_reg + (2*SAMPLE_W+2)'(32768);
        lane_result = a_reg + rounded[2*SAMPLE_W-1:SAMPLE_W];

        res_packed = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            res_packed[c*SAMPLE_W +: SAMPLE_W] = res_reg[c];
        end
    end

    always_comb
    begin
        slot_free  = !out_valid_reg || m_axis_tready;
        phase_sum  = {1'b0, phase_reg} + {1'b0, cur_ratio_reg[CUR_W-1:8]};
        phase_next = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
        run_more   = (phase_next < ONE_Q16) && (cnt_reg != CNT_W'(RUN_CAP - 1));

        goal      = {target_reg, 8'h00};
        ratio_sum = $signed({2'b00, cur_ratio_reg}) + $signed({step_reg[STEP_W-1], step_reg});
        if (ratio_sum[CUR_W+1])
        begin
            ratio_clamped = '0;
        end
        else if (ratio_sum[CUR_W])
        begin
            ratio_clamped = CUR_MAX;
        end
        else
        begin
            ratio_clamped = ratio_sum[CUR_W-1:0];
        end

        // The last tick of a ramp lands exactly on the target.
        if (ramp_cnt_reg > RAMP_W'(1))
        begin
            cur_ratio_next = ratio_clamped;
            ramp_cnt_next  = ramp_cnt_reg - 1'b1;
        end
        else
        begin
            cur_ratio_next = goal;
            ramp_cnt_next  = '0;
        end

        target_write     = cfg_we && (cfg_index_t'(cfg_addr) == CFG_TARGET_RATIO);
        target_diff      = {1'b0, cfg_wdata[RATIO_W-1:0], 8'h00} - {1'b0, cur_ratio_reg};
        target_diff_neg  = -target_diff;
        div_req.start    = target_write && (ramp_frames_reg != '0);
        div_req.negative = target_diff[CUR_W];
        div_req.magnitude = target_diff[CUR_W] ? target_diff_neg[CUR_W-1:0]
                                               : target_diff[CUR_W-1:0];
        div_req.divisor  = ramp_frames_reg;
    end

    assign busy          = div_rsp.busy;
    assign pop           = (state_reg == ST_IDLE) && q_stat.not_empty && !div_rsp.busy;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ch_reg          <= '0;
            s1_valid_reg    <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            num_ch_reg      <= NUM_CH_RST;
            target_reg      <= TARGET_RST;
            ramp_frames_reg <= RAMP_RST;
            phase_reg       <= '0;
            cur_ratio_reg   <= CUR_RST;
            step_reg        <= '0;
            ramp_cnt_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= 1'b0;
            // An emit in the same cycle refills the slot instead.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (pop && !head.load_only)
                    begin
                        cnt_reg <= '0;
                        ch_reg  <= '0;
                        state_reg <= (phase_reg < ONE_Q16) ? ST_MAC : ST_FINISH;
                    end
                end
                ST_MAC:
                begin
                    s1_valid_reg <= 1'b1;
                    ch_reg       <= ch_reg + 1'b1;
                    if (ch_reg == LAST_CH)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        phase_reg     <= phase_next;
                        cur_ratio_reg <= cur_ratio_next;
                        ramp_cnt_reg  <= ramp_cnt_next;
                        cnt_reg       <= cnt_reg + 1'b1;
                        ch_reg        <= '0;
                        state_reg     <= run_more ? ST_MAC : ST_FINISH;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    // A run cut short by the output cap leaves the phase at zero.
                    phase_reg <= (phase_reg >= ONE_Q16) ? phase_reg - ONE_Q16 : '0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (div_rsp.done)
            begin
                step_reg <= div_rsp.quotient;
            end

            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_NUM_CHANNELS:
                    begin
                        num_ch_reg <= cfg_wdata[CFG_CH_W-1:0];
                    end
                    CFG_TARGET_RATIO:
                    begin
                        target_reg   <= cfg_wdata[RATIO_W-1:0];
                        ramp_cnt_reg <= ramp_frames_reg;
                        if (ramp_frames_reg == '0)
                        begin
                            cur_ratio_reg <= {cfg_wdata[RATIO_W-1:0], 8'h00};
                            step_reg      <= '0;
                        end
                    end
                    CFG_RAMP_FRAMES:
                    begin
                        ramp_frames_reg <= cfg_wdata[RAMP_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                if (head.load_only)
                begin
                    prev_reg[c] <= head_samples[c];
                end
                else
                begin
                    cur_reg[c] <= head_samples[c];
                end
            end
        end
        if (state_reg == ST_FINISH)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                prev_reg[c] <= cur_reg[c];
            end
        end
        if (state_reg == ST_MAC)
        begin
            prod_reg <= lane_active ? lane_prod : '0;
            a_reg    <= lane_active ? prev_s : '0;
            idx_reg  <= ch_reg;
        end
        if (s1_valid_reg)
        begin
            res_reg[idx_reg] <= lane_result;
        end
        if ((state_reg == ST_EMIT) && slot_free)
        begin
            out_data_reg <= res_packed;
            out_last_reg <= !run_more;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lir_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 20000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 32;

    typedef logic signed [SAMPLE_W-1:0] frame_t [MAX_CHANNELS_DEF];

    typedef struct packed {
        logic               last;
        logic [TDATA_W-1:0] data;
    } out_frame_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sample_0 .. sample_7, 16 bits each, sample_0 in the lowest bits
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_0 .. out_7, 16 bits each, out_0 in the lowest bits
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we        = 1'b0;
    cfg_index_t            cfg_addr      = CFG_NUM_CHANNELS;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    // Resampler state as the testbench sees it.
    logic [CFG_CH_W-1:0]      cfg_chans;
    logic [RATIO_W-1:0]       cfg_target;
    logic [RAMP_W-1:0]        cfg_ramp;
    frame_t                   hist_frame;
    bit                       hist_valid;
    logic [PHASE_W-1:0]       read_pos;
    logic [CUR_W-1:0]         cur_ratio;
    logic signed [STEP_W-1:0] ratio_inc;
    logic [RAMP_W-1:0]        ramp_left;

    logic [TDATA_W-1:0] frame_feed [$];
    out_frame_t         pending_out [$];

    int errors        = 0;
    int frames_queued = 0;
    int frames_in     = 0;
    int frames_out    = 0;
    int longest_run   = 0;
    int settings_seen = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int tx_gap        = 0;
    int tx_quiet      = 0;
    int rx_gap        = 0;
    int rx_quiet      = 0;
    int idle_cycles   = 0;

    linear_interp_resampler i_dut (.*);

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TDATA_W-1:0] rand_frame();
        logic [TDATA_W-1:0] d;
        for (int c = 0; c < NUM_FIELDS; c++)
        begin
            case ($urandom_range(0, 9))
                0:       d[c*SAMPLE_W +: SAMPLE_W] = 16'h7FFF;
                1:       d[c*SAMPLE_W +: SAMPLE_W] = 16'h8000;
                default: d[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom());
            endcase
        end
        return d;
    endfunction

    // Works out every output frame that one accepted input frame causes.
    task automatic predict_frame(input logic [TDATA_W-1:0] data);
        frame_t             fresh;
        out_frame_t         run [$];
        out_frame_t         f;
        int                 used;
        logic [PHASE_W:0]   sum;
        longint             acc;
        longint             t;
        for (int c = 0; c < MAX_CHANNELS_DEF; c++)
            fresh[c] = data[c*SAMPLE_W +: SAMPLE_W];
        if (!hist_valid)
        begin
            hist_frame = fresh;
            hist_valid = 1'b1;
            return;
        end
        used = (cfg_chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : int'(cfg_chans);
        while (read_pos < ONE_Q16 && run.size() < RUN_CAP)
        begin
            f = '0;
            for (int c = 0; c < used; c++)
            begin
                // Floor of the shifted sum gives rounding half toward plus infinity.
                acc = longint'(hist_frame[c]) * 65536
                    + (longint'(fresh[c]) - longint'(hist_frame[c])) * longint'(read_pos)
                    + 32768;
                f.data[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(acc >>> 16);
            end
            run.push_back(f);
            sum = read_pos + cur_ratio[CUR_W-1:8];
            read_pos = (sum > PHASE_MAX) ? PHASE_MAX : sum[PHASE_W-1:0];
            if (ramp_left > 1)
            begin
                t = longint'(cur_ratio) + longint'(ratio_inc);
                if (t < 0)
                    t = 0;
                if (t > longint'(CUR_MAX))
                    t = longint'(CUR_MAX);
                cur_ratio = CUR_W'(t);
                ramp_left = ramp_left - 1'b1;
            end
            else
            begin
                cur_ratio = {cfg_target, 8'h00};
                ramp_left = '0;
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        if (run.size() > longest_run)
            longest_run = run.size();
        foreach (run[i])
            pending_out.push_back(run[i]);
        // A run cut short by the cap leaves the phase below one; it restarts at zero.
        read_pos = (read_pos >= ONE_Q16) ? read_pos - ONE_Q16 : '0;
        hist_frame = fresh;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        longint diff;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_NUM_CHANNELS: cfg_chans = val[CFG_CH_W-1:0];
            CFG_RAMP_FRAMES:  cfg_ramp  = val[RAMP_W-1:0];
            CFG_TARGET_RATIO:
            begin
                cfg_target = val[RATIO_W-1:0];
                ramp_left  = cfg_ramp;
                if (cfg_ramp == 0)
                begin
                    cur_ratio = {cfg_target, 8'h00};
                    ratio_inc = '0;
                end
                else
                begin
                    diff      = longint'({cfg_target, 8'h00}) - longint'(cur_ratio);
                    ratio_inc = STEP_W'(diff / longint'(cfg_ramp));
                end
            end
            default: ;
        endcase
    endtask

    // The ramp length goes first since a target write latches it.
    task automatic configure(input int chans, input int ramp, input int target);
        write_reg(CFG_NUM_CHANNELS, CFG_DATA_W'(chans));
        write_reg(CFG_RAMP_FRAMES, CFG_DATA_W'(ramp));
        write_reg(CFG_TARGET_RATIO, CFG_DATA_W'(target));
        settings_seen++;
        @(negedge clk);
    endtask

    task automatic push_frame(input logic [TDATA_W-1:0] data);
        frame_feed.push_back(data);
        frames_queued++;
    endtask

    task automatic wait_idle();
        while (frames_in != frames_queued || pending_out.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                frame_feed.delete(0);
                if (tx_quiet > 0)
                begin
                    tx_quiet--;
                    tx_gap = 0;
                end
                else if ($urandom_range(0, 49) == 0)
                    tx_quiet = 100;
                else
                    tx_gap = pick_gap();
            end
            // An offered item stays on the bus until it is taken.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (frame_feed.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= frame_feed[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (hold_served != hold_asks)
            begin
                hold_served = hold_asks;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (rx_quiet > 0)
                    rx_quiet--;
                else if ($urandom_range(0, 199) == 0)
                    rx_quiet = 150;
                else
                    rx_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        out_frame_t want;
        if (rst_n)
        begin
            // Outputs are checked first: they always belong to earlier input items.
            if (m_axis_tvalid && m_axis_tready)
            begin
                frames_out++;
                if (pending_out.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output item: expected none, got data=%h last=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = pending_out.pop_front();
                    for (int c = 0; c < NUM_FIELDS; c++)
                    begin
                        if (m_axis_tdata[c*SAMPLE_W +: SAMPLE_W]
                            !== want.data[c*SAMPLE_W +: SAMPLE_W])
                        begin
                            errors++;
                            $display("%0t: out_%0d mismatch: expected %h, got %h", $time, c,
                                     want.data[c*SAMPLE_W +: SAMPLE_W],
                                     m_axis_tdata[c*SAMPLE_W +: SAMPLE_W]);
                        end
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_of_run mismatch: expected %b, got %b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_frame(s_axis_tdata);
                frames_in++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int chans;
        int ramp;
        int target;
        cfg_chans  = NUM_CH_RST;
        cfg_target = TARGET_RST;
        cfg_ramp   = RAMP_RST;
        foreach (hist_frame[c])
            hist_frame[c] = '0;
        hist_valid = 1'b0;
        read_pos   = '0;
        cur_ratio  = CUR_RST;
        ratio_inc  = '0;
        ramp_left  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Half-step ratio: the first item only loads history, then midpoints hit rounding.
        configure(8, 0, 20'h08000);
        push_frame('0);
        push_frame({NUM_FIELDS{16'h7FFF}});
        push_frame({NUM_FIELDS{16'h8000}});
        push_frame({NUM_FIELDS{16'h7FFF}});
        push_frame({(NUM_FIELDS/2){16'h8000, 16'h7FFF}});
        push_frame({(NUM_FIELDS/2){16'h7FFF, 16'h8000}});
        push_frame({NUM_FIELDS{16'hFFFF}});
        push_frame({NUM_FIELDS{16'h0001}});
        push_frame(rand_frame());
        push_frame('0);
        wait_idle();

        // Short ramp up to a ratio of two, so some items give no output.
        configure(5, 4, 20'h20000);
        repeat (5) push_frame(rand_frame());
        wait_idle();

        // A zero ratio never moves the phase: every run ends on the cap.
        configure(3, 0, 0);
        repeat (2) push_frame(rand_frame());
        wait_idle();

        // Smallest legal step with an out-of-range channel count.
        configure(15, 0, 1024);
        repeat (2) push_frame(rand_frame());
        wait_idle();

        // Largest step saturates the phase; no channel is in use.
        configure(0, 0, 20'hFFFFF);
        repeat (3) push_frame(rand_frame());
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       chans = 0;
                1:       chans = $urandom_range(9, 15);
                default: chans = $urandom_range(1, 8);
            endcase
            if (ph == 3)
                ramp = 65535;
            else if (ph == RANDOM_PHASES - 1 || $urandom_range(0, 2) == 0)
                ramp = 0;
            else
                ramp = $urandom_range(1, 48);
            case ($urandom_range(0, 9))
                0:       target = $urandom_range(1024, 8191);
                1:       target = $urandom_range(150000, 20'hFFFFF);
                default: target = $urandom_range(8192, 150000);
            endcase
            configure(chans, ramp, target);
            // One phase starts with a long receiver stall so the input backs up.
            if (ph == 2)
                hold_asks++;
            repeat (PHASE_ITEMS) push_frame(rand_frame());
            wait_idle();
        end

        if (pending_out.size() != 0)
        begin
            errors += pending_out.size();
            $display("%0t: %0d output items still expected, got none", $time,
                     pending_out.size());
        end
        $display("Run covered %0d input frames and %0d output frames over %0d register settings.",
                 frames_in, frames_out, settings_seen);
        $display("Longest output run per input frame: %0d; mismatches: %0d.",
                 longest_run, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
